// ----- rtl/svgn_pkg.sv -----
// Shared types, command codes and segment codes for the SVG path normalizer.
`timescale 1ns / 1ps

package svgn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_COORDS      = 7;

    // input command kinds
    localparam logic [3:0] CMD_MOVE     = 4'd0;
    localparam logic [3:0] CMD_LINE     = 4'd1;
    localparam logic [3:0] CMD_HORIZ    = 4'd2;
    localparam logic [3:0] CMD_VERT     = 4'd3;
    localparam logic [3:0] CMD_CUBIC    = 4'd4;
    localparam logic [3:0] CMD_S_CUBIC  = 4'd5;
    localparam logic [3:0] CMD_QUAD     = 4'd6;
    localparam logic [3:0] CMD_S_QUAD   = 4'd7;
    localparam logic [3:0] CMD_ARC      = 4'd8;
    localparam logic [3:0] CMD_CLOSE    = 4'd9;

    // output segment kinds
    localparam logic [2:0] SEG_MOVE  = 3'd0;
    localparam logic [2:0] SEG_LINE  = 3'd1;
    localparam logic [2:0] SEG_CUBIC = 3'd2;
    localparam logic [2:0] SEG_QUAD  = 3'd3;
    localparam logic [2:0] SEG_ARC   = 3'd4;
    localparam logic [2:0] SEG_CLOSE = 3'd5;

    typedef struct packed {
        logic [3:0]                       cmd;
        logic                             relative;
        logic                             first_group;
        logic [NUM_COORDS-1:0][31:0]      p;
    } t_item;

    typedef struct packed {
        logic [2:0]  seg_kind;
        logic [31:0] c1_x;
        logic [31:0] c1_y;
        logic [31:0] c2_x;
        logic [31:0] c2_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic        large_arc;
        logic        sweep_neg;
    } t_seg;

endpackage

// ----- rtl/svg_path_command_normalizer.sv -----
// Top level of the SVG path command normalizer.
// One coordinate group enters per cycle while neither side stalls; its absolute segment passes
// from the input register through the resolving logic into the result register. The resolving
// logic writes the result register and updates the pen state (current point, last control,
// subpath start, previous kind) in the same cycle, so the next group already sees it.
// Sustained rate is one item per clock while the output side does not stall; an unknown
// command kind is consumed and gives no result. COORD_WIDTH sets the internal wrap width
// of all coordinate math.
`timescale 1ns / 1ps

module svg_path_command_normalizer
    import svgn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_cmd,
    input  logic               i_relative,
    input  logic               i_first_group,
    input  logic signed [31:0] i_p0,
    input  logic signed [31:0] i_p1,
    input  logic signed [31:0] i_p2,
    input  logic signed [31:0] i_p3,
    input  logic signed [31:0] i_p4,
    input  logic signed [31:0] i_p5,
    input  logic signed [31:0] i_p6,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_seg_kind,
    output logic signed [31:0] o_c1_x,
    output logic signed [31:0] o_c1_y,
    output logic signed [31:0] o_c2_x,
    output logic signed [31:0] o_c2_y,
    output logic signed [31:0] o_end_x,
    output logic signed [31:0] o_end_y,
    output logic               o_large_arc,
    output logic               o_sweep_neg
);

    t_item w_in_item;
    t_item w_held_item;
    logic  w_held;
    logic  w_advance;
    logic  w_known;
    t_seg  w_core_seg;
    t_seg  w_out_seg;

    assign w_in_item.cmd         = i_cmd;
    assign w_in_item.relative    = i_relative;
    assign w_in_item.first_group = i_first_group;
    assign w_in_item.p[0]        = i_p0;
    assign w_in_item.p[1]        = i_p1;
    assign w_in_item.p[2]        = i_p2;
    assign w_in_item.p[3]        = i_p3;
    assign w_in_item.p[4]        = i_p4;
    assign w_in_item.p[5]        = i_p5;
    assign w_in_item.p[6]        = i_p6;

    // item moves on when the result register is free or draining
    assign w_advance = w_held && (!o_valid || !i_stall);

    svgn_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_held    (w_held),
        .o_item    (w_held_item)
    );

    svgn_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_held_item),
        .i_advance (w_advance),
        .o_known   (w_known),
        .o_seg     (w_core_seg)
    );

    svgn_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_known (w_known),
        .i_seg   (w_core_seg),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_seg   (w_out_seg)
    );

    assign o_seg_kind  = w_out_seg.seg_kind;
    assign o_c1_x      = w_out_seg.c1_x;
    assign o_c1_y      = w_out_seg.c1_y;
    assign o_c2_x      = w_out_seg.c2_x;
    assign o_c2_y      = w_out_seg.c2_y;
    assign o_end_x     = w_out_seg.end_x;
    assign o_end_y     = w_out_seg.end_y;
    assign o_large_arc = w_out_seg.large_arc;
    assign o_sweep_neg = w_out_seg.sweep_neg;

    a_unknown_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_known) |=> !o_valid)
        else $error("unknown command produced a result");

    a_known_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_known) |=> o_valid)
        else $error("resolved item did not reach the result register");

    a_flags_arc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seg_kind != SEG_ARC) |-> (!o_large_arc && !o_sweep_neg))
        else $error("arc flags set on a non-arc segment");

    a_close_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seg_kind == SEG_CLOSE) |->
            (o_c1_x == '0 && o_c1_y == '0 && o_c2_x == '0 && o_c2_y == '0))
        else $error("close segment carries control points");

endmodule

// ----- rtl/svgn_in_reg.sv -----
// Input register stage: captures one item and holds it until the core consumes it.
`timescale 1ns / 1ps

module svgn_in_reg
    import svgn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_held,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;
    assign n_valid  = w_accept || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_held = r_valid;
    assign o_item = r_item;

endmodule

// ----- rtl/svgn_core.sv -----
// Normalizer core: resolves one item to an absolute segment and keeps the pen state.
`timescale 1ns / 1ps

module svgn_core
    import svgn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_known,
    output t_seg  o_seg
);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    t_coord     r_cur_x, r_cur_y, r_ctl_x, r_ctl_y, r_sub_x, r_sub_y;
    t_coord     n_cur_x, n_cur_y, n_ctl_x, n_ctl_y, n_sub_x, n_sub_y;
    logic [3:0] r_prev_kind;

    t_coord     w_p [NUM_COORDS];
    t_coord     w_bx, w_by;
    t_coord     w_refl_x, w_refl_y;
    t_coord     w_c1x, w_c1y, w_c2x, w_c2y, w_ex, w_ey;
    logic [2:0] w_kind;
    logic       w_large, w_sweep;
    logic       w_known;

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            w_p[k] = COORD_WIDTH'(signed'(i_item.p[k]));
        end
    end

    assign w_bx     = i_item.relative ? r_cur_x : '0;
    assign w_by     = i_item.relative ? r_cur_y : '0;
    // reflection of the last control point through the current point
    assign w_refl_x = (r_cur_x <<< 1) - r_ctl_x;
    assign w_refl_y = (r_cur_y <<< 1) - r_ctl_y;

    always_comb begin
        w_kind  = SEG_MOVE;
        w_c1x   = '0;
        w_c1y   = '0;
        w_c2x   = '0;
        w_c2y   = '0;
        w_ex    = '0;
        w_ey    = '0;
        w_large = 1'b0;
        w_sweep = 1'b0;
        w_known = 1'b1;
        n_ctl_x = r_ctl_x;
        n_ctl_y = r_ctl_y;
        n_sub_x = r_sub_x;
        n_sub_y = r_sub_y;
        case (i_item.cmd)
            CMD_MOVE, CMD_LINE: begin
                w_ex = w_bx + w_p[0];
                w_ey = w_by + w_p[1];
                if (i_item.cmd == CMD_MOVE && i_item.first_group) begin
                    w_kind  = SEG_MOVE;
                    n_sub_x = w_ex;
                    n_sub_y = w_ey;
                end else begin
                    w_kind = SEG_LINE;
                end
            end
            CMD_HORIZ: begin
                w_kind = SEG_LINE;
                w_ex   = w_bx + w_p[0];
                w_ey   = r_cur_y;
            end
            CMD_VERT: begin
                w_kind = SEG_LINE;
                w_ex   = r_cur_x;
                w_ey   = w_by + w_p[0];
            end
            CMD_CUBIC: begin
                w_kind  = SEG_CUBIC;
                w_c1x   = w_bx + w_p[0];
                w_c1y   = w_by + w_p[1];
                w_c2x   = w_bx + w_p[2];
                w_c2y   = w_by + w_p[3];
                w_ex    = w_bx + w_p[4];
                w_ey    = w_by + w_p[5];
                n_ctl_x = w_c2x;
                n_ctl_y = w_c2y;
            end
            CMD_S_CUBIC: begin
                w_kind = SEG_CUBIC;
                if (r_prev_kind inside {CMD_CUBIC, CMD_S_CUBIC}) begin
                    w_c1x = w_refl_x;
                    w_c1y = w_refl_y;
                end else begin
                    w_c1x = r_cur_x;
                    w_c1y = r_cur_y;
                end
                w_c2x   = w_bx + w_p[0];
                w_c2y   = w_by + w_p[1];
                w_ex    = w_bx + w_p[2];
                w_ey    = w_by + w_p[3];
                n_ctl_x = w_c2x;
                n_ctl_y = w_c2y;
            end
            CMD_QUAD: begin
                w_kind  = SEG_QUAD;
                w_c1x   = w_bx + w_p[0];
                w_c1y   = w_by + w_p[1];
                w_ex    = w_bx + w_p[2];
                w_ey    = w_by + w_p[3];
                n_ctl_x = w_c1x;
                n_ctl_y = w_c1y;
            end
            CMD_S_QUAD: begin
                w_kind = SEG_QUAD;
                if (r_prev_kind inside {CMD_QUAD, CMD_S_QUAD}) begin
                    w_c1x = w_refl_x;
                    w_c1y = w_refl_y;
                end else begin
                    w_c1x = r_cur_x;
                    w_c1y = r_cur_y;
                end
                w_ex    = w_bx + w_p[0];
                w_ey    = w_by + w_p[1];
                n_ctl_x = w_c1x;
                n_ctl_y = w_c1y;
            end
            CMD_ARC: begin
                w_kind  = SEG_ARC;
                w_c1x   = w_p[0];
                w_c1y   = w_p[1];
                w_c2x   = w_p[2];
                // flags look at the raw 32-bit fields
                w_large = (i_item.p[3] != '0);
                w_sweep = (i_item.p[4] == '0);
                w_ex    = w_bx + w_p[5];
                w_ey    = w_by + w_p[6];
                n_ctl_x = w_ex;
                n_ctl_y = w_ey;
            end
            CMD_CLOSE: begin
                w_kind  = SEG_CLOSE;
                w_ex    = r_sub_x;
                w_ey    = r_sub_y;
                n_ctl_x = r_sub_x;
                n_ctl_y = r_sub_y;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
        n_cur_x = w_ex;
        n_cur_y = w_ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_ctl_x     <= '0;
            r_ctl_y     <= '0;
            r_sub_x     <= '0;
            r_sub_y     <= '0;
            r_prev_kind <= CMD_MOVE;
        end else if (i_advance && w_known) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_ctl_x     <= n_ctl_x;
            r_ctl_y     <= n_ctl_y;
            r_sub_x     <= n_sub_x;
            r_sub_y     <= n_sub_y;
            r_prev_kind <= i_item.cmd;
        end
    end

    assign o_known         = w_known;
    assign o_seg.seg_kind  = w_kind;
    assign o_seg.c1_x      = 32'(w_c1x);
    assign o_seg.c1_y      = 32'(w_c1y);
    assign o_seg.c2_x      = 32'(w_c2x);
    assign o_seg.c2_y      = 32'(w_c2y);
    assign o_seg.end_x     = 32'(w_ex);
    assign o_seg.end_y     = 32'(w_ey);
    assign o_seg.large_arc = w_large;
    assign o_seg.sweep_neg = w_sweep;

endmodule

// ----- rtl/svgn_out_reg.sv -----
// Result register: holds one segment until the downstream side takes it.
`timescale 1ns / 1ps

module svgn_out_reg
    import svgn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_known,
    input  t_seg i_seg,
    input  logic i_stall,
    output logic o_valid,
    output t_seg o_seg
);

    logic r_valid;
    t_seg r_seg;

    // i_load is only raised when this register is empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_known;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_known) begin
            r_seg <= i_seg;
        end
    end

    assign o_valid = r_valid;
    assign o_seg   = r_seg;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the SVG path command normalizer.
`timescale 1ns / 1ps

module testbench;
    import svgn_pkg::*;

    localparam int RAND_GROUPS = 1950;
    localparam int MAX_SHOWN   = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_cmd;
    logic        i_relative;
    logic        i_first_group;
    logic [31:0] i_p0, i_p1, i_p2, i_p3, i_p4, i_p5, i_p6;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_seg_kind;
    logic [31:0] o_c1_x, o_c1_y, o_c2_x, o_c2_y, o_end_x, o_end_y;
    logic        o_large_arc;
    logic        o_sweep_neg;

    svg_path_command_normalizer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_relative    (i_relative),
        .i_first_group (i_first_group),
        .i_p0          (i_p0),
        .i_p1          (i_p1),
        .i_p2          (i_p2),
        .i_p3          (i_p3),
        .i_p4          (i_p4),
        .i_p5          (i_p5),
        .i_p6          (i_p6),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_seg_kind    (o_seg_kind),
        .o_c1_x        (o_c1_x),
        .o_c1_y        (o_c1_y),
        .o_c2_x        (o_c2_x),
        .o_c2_y        (o_c2_y),
        .o_end_x       (o_end_x),
        .o_end_y       (o_end_y),
        .o_large_arc   (o_large_arc),
        .o_sweep_neg   (o_sweep_neg)
    );

    t_item pending_groups[$];
    t_seg  expected_segs[$];
    int    fail_count = 0;
    int    groups_taken = 0;
    int    known_groups = 0;
    logic  drv_taken = 1'b0;
    logic  steady;

    // pen state of the predictor
    logic [31:0] pen_x, pen_y, ctrl_x, ctrl_y, start_x, start_y;
    logic [3:0]  last_cmd;

    // long window with no idling on either side
    assign steady = (groups_taken >= 900) && (groups_taken < 1200);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic normalize_group(input t_item g);
        t_seg        s;
        logic [31:0] bx, by;
        bx = g.relative ? pen_x : 32'd0;
        by = g.relative ? pen_y : 32'd0;
        s  = '0;
        case (g.cmd)
            CMD_MOVE, CMD_LINE: begin
                s.end_x = bx + g.p[0];
                s.end_y = by + g.p[1];
                if (g.cmd == CMD_MOVE && g.first_group) begin
                    s.seg_kind = SEG_MOVE;
                    start_x    = s.end_x;
                    start_y    = s.end_y;
                end else begin
                    s.seg_kind = SEG_LINE;
                end
            end
            CMD_HORIZ: begin
                s.seg_kind = SEG_LINE;
                s.end_x    = bx + g.p[0];
                s.end_y    = pen_y;
            end
            CMD_VERT: begin
                s.seg_kind = SEG_LINE;
                s.end_x    = pen_x;
                s.end_y    = by + g.p[0];
            end
            CMD_CUBIC: begin
                s.seg_kind = SEG_CUBIC;
                s.c1_x  = bx + g.p[0];
                s.c1_y  = by + g.p[1];
                s.c2_x  = bx + g.p[2];
                s.c2_y  = by + g.p[3];
                s.end_x = bx + g.p[4];
                s.end_y = by + g.p[5];
                ctrl_x  = s.c2_x;
                ctrl_y  = s.c2_y;
            end
            CMD_S_CUBIC: begin
                s.seg_kind = SEG_CUBIC;
                if (last_cmd == CMD_CUBIC || last_cmd == CMD_S_CUBIC) begin
                    s.c1_x = (pen_x << 1) - ctrl_x;
                    s.c1_y = (pen_y << 1) - ctrl_y;
                end else begin
                    s.c1_x = pen_x;
                    s.c1_y = pen_y;
                end
                s.c2_x  = bx + g.p[0];
                s.c2_y  = by + g.p[1];
                s.end_x = bx + g.p[2];
                s.end_y = by + g.p[3];
                ctrl_x  = s.c2_x;
                ctrl_y  = s.c2_y;
            end
            CMD_QUAD: begin
                s.seg_kind = SEG_QUAD;
                s.c1_x  = bx + g.p[0];
                s.c1_y  = by + g.p[1];
                s.end_x = bx + g.p[2];
                s.end_y = by + g.p[3];
                ctrl_x  = s.c1_x;
                ctrl_y  = s.c1_y;
            end
            CMD_S_QUAD: begin
                s.seg_kind = SEG_QUAD;
                if (last_cmd == CMD_QUAD || last_cmd == CMD_S_QUAD) begin
                    s.c1_x = (pen_x << 1) - ctrl_x;
                    s.c1_y = (pen_y << 1) - ctrl_y;
                end else begin
                    s.c1_x = pen_x;
                    s.c1_y = pen_y;
                end
                s.end_x = bx + g.p[0];
                s.end_y = by + g.p[1];
                ctrl_x  = s.c1_x;
                ctrl_y  = s.c1_y;
            end
            CMD_ARC: begin
                s.seg_kind  = SEG_ARC;
                s.c1_x      = g.p[0];
                s.c1_y      = g.p[1];
                s.c2_x      = g.p[2];
                s.large_arc = (g.p[3] != 32'd0);
                s.sweep_neg = (g.p[4] == 32'd0);
                s.end_x     = bx + g.p[5];
                s.end_y     = by + g.p[6];
                ctrl_x      = s.end_x;
                ctrl_y      = s.end_y;
            end
            CMD_CLOSE: begin
                s.seg_kind = SEG_CLOSE;
                s.end_x    = start_x;
                s.end_y    = start_y;
                ctrl_x     = start_x;
                ctrl_y     = start_y;
            end
            default: return;  // unknown kind: consumed, no segment, no state change
        endcase
        pen_x    = s.end_x;
        pen_y    = s.end_y;
        last_cmd = g.cmd;
        expected_segs.push_back(s);
    endtask

    task automatic add_group(input logic [3:0] c, input logic rel, input logic first,
                             input logic [31:0] a, b, d, e, f, h, k);
        t_item g;
        g.cmd         = c;
        g.relative    = rel;
        g.first_group = first;
        g.p[0] = a; g.p[1] = b; g.p[2] = d; g.p[3] = e;
        g.p[4] = f; g.p[5] = h; g.p[6] = k;
        pending_groups.push_back(g);
        if (c <= CMD_CLOSE)
            known_groups++;
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3, 4, 5: return r;
            default: return {{12{r[19]}}, r[19:0]};  // within +-8.0
        endcase
    endfunction

    task automatic add_random_group(input logic [3:0] c, input logic first);
        logic [31:0] fl, sw;
        fl = $urandom_range(0, 1) ? 32'd0 : rand_coord();
        sw = $urandom_range(0, 1) ? 32'd0 : rand_coord();
        if (c == CMD_ARC)
            add_group(c, 1'($urandom_range(0, 1)), first, rand_coord(), rand_coord(),
                      rand_coord(), fl, sw, rand_coord(), rand_coord());
        else
            add_group(c, 1'($urandom_range(0, 1)), first, rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // driver: accept at the rising edge, present the next group at the falling edge
    always @(posedge i_clk) begin
        drv_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            normalize_group(pending_groups.pop_front());
            groups_taken <= groups_taken + 1;
        end
    end

    always @(negedge i_clk) begin : drive
        t_item g;
        logic  idle_now;
        idle_now = !steady && ($urandom_range(0, 99) < 13);
        if (i_rst_n && (!i_valid || drv_taken)) begin
            if (pending_groups.size() != 0 && !idle_now) begin
                g = pending_groups[0];
                i_valid       <= 1'b1;
                i_cmd         <= g.cmd;
                i_relative    <= g.relative;
                i_first_group <= g.first_group;
                i_p0 <= g.p[0]; i_p1 <= g.p[1]; i_p2 <= g.p[2]; i_p3 <= g.p[3];
                i_p4 <= g.p[4]; i_p5 <= g.p[5]; i_p6 <= g.p[6];
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (i_rst_n)
            i_stall <= !steady && ($urandom_range(0, 99) < 13);
    end

    // monitor
    always @(posedge i_clk) begin : check
        t_seg got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.seg_kind  = o_seg_kind;
            got.c1_x      = o_c1_x;
            got.c1_y      = o_c1_y;
            got.c2_x      = o_c2_x;
            got.c2_y      = o_c2_y;
            got.end_x     = o_end_x;
            got.end_y     = o_end_y;
            got.large_arc = o_large_arc;
            got.sweep_neg = o_sweep_neg;
            if (expected_segs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected segment: kind %0d end %h %h",
                             got.seg_kind, got.end_x, got.end_y);
            end else begin
                want = expected_segs.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("segment mismatch at %0t", $realtime);
                        $display("  exp kind %0d c1 %h %h c2 %h %h end %h %h la %b sn %b",
                                 want.seg_kind, want.c1_x, want.c1_y, want.c2_x,
                                 want.c2_y, want.end_x, want.end_y, want.large_arc,
                                 want.sweep_neg);
                        $display("  got kind %0d c1 %h %h c2 %h %h end %h %h la %b sn %b",
                                 got.seg_kind, got.c1_x, got.c1_y, got.c2_x,
                                 got.c2_y, got.end_x, got.end_y, got.large_arc,
                                 got.sweep_neg);
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : main
        int          path_len;
        logic [3:0]  c;
        logic [3:0]  prev_c;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = '0; i_relative = 1'b0; i_first_group = 1'b0;
        i_p0 = '0; i_p1 = '0; i_p2 = '0; i_p3 = '0; i_p4 = '0; i_p5 = '0; i_p6 = '0;
        pen_x = '0; pen_y = '0; ctrl_x = '0; ctrl_y = '0; start_x = '0; start_y = '0;
        last_cmd = CMD_MOVE;

        // directed groups
        add_group(CMD_MOVE,    0, 1, 32'h0001_0000, 32'h0002_0000, 0, 0, 0, 0, 0);
        add_group(CMD_LINE,    1, 1, 32'h0003_8000, 32'hFFFF_0000, 0, 0, 0, 0, 0);
        add_group(CMD_HORIZ,   0, 1, 32'h7FFF_FFFF, 32'h1234_5678, 0, 0, 0, 0, 0);
        add_group(CMD_VERT,    1, 1, 32'h7FFF_FFFF, 32'h1111_1111, 0, 0, 0, 0, 0);
        add_group(CMD_CUBIC,   0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0004_0000,
                  32'hFFFC_0000, 32'h0008_0000, 32'h0001_0000, 32'hDEAD_BEEF);
        add_group(CMD_S_CUBIC, 1, 1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0004_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_group(CMD_S_CUBIC, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000,
                  32'h0006_0000, 0, 0, 0);
        add_group(CMD_QUAD,    1, 1, 32'h0002_0000, 32'hFFFE_0000, 32'h0004_0000,
                  32'h0000_8000, 0, 0, 0);
        add_group(CMD_S_QUAD,  1, 1, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 0);
        add_group(CMD_S_QUAD,  0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        // smooth cubic after a quad: no reflection
        add_group(CMD_S_CUBIC, 0, 1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0004_0000, 0, 0, 0);
        add_group(CMD_LINE,    0, 1, 32'h0010_0000, 32'h0020_0000, 0, 0, 0, 0, 0);
        // smooth quad after a line: no reflection
        add_group(CMD_S_QUAD,  1, 1, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 0);
        add_group(CMD_ARC,     0, 1, 32'h0005_0000, 32'h0003_0000, 32'h002D_0000,
                  32'd0, 32'd0, 32'h0007_0000, 32'h0008_0000);
        add_group(CMD_ARC,     1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        add_group(CMD_S_CUBIC, 1, 1, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                  32'h0002_0000, 0, 0, 0);
        add_group(CMD_CLOSE,   0, 0, 0, 0, 0, 0, 0, 0, 0);
        // move group that continues a move command: becomes a line
        add_group(CMD_MOVE,    1, 0, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 0, 0);
        add_group(CMD_CLOSE + 4'd1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_group(4'hF,        0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_group(CMD_MOVE,    1, 1, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_group(CMD_LINE,    1, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        add_group(CMD_HORIZ,   1, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        add_group(CMD_VERT,    0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        // close ignores its coordinates and flags
        add_group(CMD_CLOSE,   1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // random paths: a move, a run of drawing groups, a close half the time
        known_groups = 0;
        while (known_groups < RAND_GROUPS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_random_group(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            end else begin
                add_random_group(CMD_MOVE, 1'b1);
                prev_c   = CMD_MOVE;
                path_len = $urandom_range(1, 12);
                for (int k = 0; k < path_len; k++) begin
                    c = 4'($urandom_range(0, 9));
                    // favor smooth forms right after their own curve family
                    if ($urandom_range(0, 2) == 0) begin
                        if (prev_c == CMD_CUBIC || prev_c == CMD_S_CUBIC)
                            c = CMD_S_CUBIC;
                        else if (prev_c == CMD_QUAD || prev_c == CMD_S_QUAD)
                            c = CMD_S_QUAD;
                    end
                    add_random_group(c, (c == CMD_MOVE) ? ($urandom_range(0, 3) == 0)
                                                        : 1'($urandom_range(0, 1)));
                    prev_c = c;
                end
                if ($urandom_range(0, 1))
                    add_random_group(CMD_CLOSE, 1'($urandom_range(0, 1)));
            end
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_groups.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_segs.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (expected_segs.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
